### hw/rtl/geo_pkg.sv
// geo_pkg: shared types and constants of the geohash encoder
// residual format of the bisection cells, interval half widths, base-32 alphabet
// no dependencies
package geo_pkg;

    // residuals and half widths in units of 2^-28 degree, offset coordinates
    localparam int RES_FRAC = 28;
    localparam int RES_W    = 37;
    localparam int SYM_BITS = 5;
    localparam int CHAR_W   = 7;
    localparam int CNT_CFG_W = 4;

    localparam logic [RES_W-1:0] LNG_HALF0 = RES_W'(360) << (RES_FRAC - 1);
    localparam logic [RES_W-1:0] LAT_HALF0 = RES_W'(180) << (RES_FRAC - 1);

    localparam logic [CHAR_W-1:0] ALPHABET [0:31] = '{
        7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
        7'h38, 7'h39, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66, 7'h67,
        7'h68, 7'h6a, 7'h6b, 7'h6d, 7'h6e, 7'h70, 7'h71, 7'h72,
        7'h73, 7'h74, 7'h75, 7'h76, 7'h77, 7'h78, 7'h79, 7'h7a
    };

    // current axis first, the other axis second; swapped by every cell
    typedef struct packed {
        logic [RES_W-1:0] cur_r;
        logic [RES_W-1:0] cur_h;
        logic [RES_W-1:0] oth_r;
        logic [RES_W-1:0] oth_h;
    } geo_axes_t;

endpackage

### hw/rtl/geohash_encoder.sv
// geohash_encoder: base-32 geohash of a latitude/longitude pair
// a row of five geo_cell bisection steps forms one character per cycle while the output is not stalled
// depends on geo_pkg, geo_cell
//
// Usage:
//   s_ channel takes one coordinate pair per item, s_tdata = {lng_deg, lat_deg},
//   signed degrees times 2^COORD_FRAC_BITS. m_ channel gives one character per
//   item, tlast on the final character, tuser[0] set when the pair was in range.
//   An out of range pair gives one item: character 0, tlast 1, tuser[0] 0.
//   cfg_we/cfg_wdata set the character count (1..MAX_CHARS, 0 acts as 1, larger
//   values as MAX_CHARS); write it only while the block is idle. Reset sets 12.
//   An accepted pair is first registered in the interval state register, and each
//   character then in the output register. While the output is not stalled, each
//   cycle the five chained cells produce one character from the interval state
//   register. The next pair is taken while the final character still waits.
//   When m_tready is low with a character waiting, the output register holds and the chain pauses.
//   Reset (aresetn low, synchronous) drops any pair in flight and empties the
//   output register.
module geohash_encoder #(
    parameter int MAX_CHARS       = 12,
    parameter int COORD_FRAC_BITS = 20
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // lat_deg [27:0], lng_deg [56:28], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // hash_char [6:0], zero pad
    output logic        m_tlast,
    output logic [0:0]  m_tuser    // valid_res [0]
);

    localparam int CNT_W = $clog2(MAX_CHARS + 1);
    localparam int CHK_W = (COORD_FRAC_BITS + 10 > 30) ? COORD_FRAC_BITS + 10 : 30;
    localparam int NCELL = geo_pkg::SYM_BITS;
    localparam logic signed [CHK_W-1:0] LAT_LIM = CHK_W'(90) <<< COORD_FRAC_BITS;
    localparam logic signed [CHK_W-1:0] LNG_LIM = CHK_W'(180) <<< COORD_FRAC_BITS;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } geo_state_t;

    geo_state_t state_reg, state_next;
    logic [geo_pkg::CNT_CFG_W-1:0] char_count_reg;
    geo_pkg::geo_axes_t axes_reg, axes_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic bad_reg, bad_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic [geo_pkg::CHAR_W-1:0] m_char_reg, m_char_next;
    logic m_last_reg, m_last_next;
    logic m_ok_reg, m_ok_next;

    logic signed [CHK_W-1:0] lat_s, lng_s, lat_off, lng_off;
    logic in_bad, accept, load, last_now;
    geo_pkg::geo_axes_t axes_init;
    geo_pkg::geo_axes_t chain [0:NCELL];
    logic [NCELL-1:0] sym;
    logic [CNT_W-1:0] n_clamp;

    genvar gi;
    generate
        for (gi = 0; gi < NCELL; gi++) begin : g_cell
            geo_cell u_cell (
                .axes_in  (chain[gi]),
                .axes_out (chain[gi+1]),
                .bit_out  (sym[NCELL-1-gi])
            );
        end
    endgenerate

    assign chain[0] = axes_reg;

    assign lat_s   = CHK_W'($signed(s_tdata[27:0]));
    assign lng_s   = CHK_W'($signed(s_tdata[56:28]));
    assign in_bad  = (lat_s > LAT_LIM) || (lat_s < -LAT_LIM) ||
                     (lng_s > LNG_LIM) || (lng_s < -LNG_LIM);
    assign lat_off = lat_s + LAT_LIM;
    assign lng_off = lng_s + LNG_LIM;

    always_comb begin
        axes_init.cur_r = geo_pkg::RES_W'($unsigned(lng_off))
                          << (geo_pkg::RES_FRAC - COORD_FRAC_BITS);
        axes_init.cur_h = geo_pkg::LNG_HALF0;
        axes_init.oth_r = geo_pkg::RES_W'($unsigned(lat_off))
                          << (geo_pkg::RES_FRAC - COORD_FRAC_BITS);
        axes_init.oth_h = geo_pkg::LAT_HALF0;
    end

    always_comb begin
        if (char_count_reg == '0) begin
            n_clamp = CNT_W'(1);
        end else if (int'(char_count_reg) > MAX_CHARS) begin
            n_clamp = CNT_W'(MAX_CHARS);
        end else begin
            n_clamp = CNT_W'(char_count_reg);
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign load     = (state_reg == ST_RUN) && (!m_tvalid_reg || m_tready);
    assign last_now = bad_reg || ((k_reg + CNT_W'(1)) == n_reg);

    always_comb begin
        state_next    = state_reg;
        axes_next     = axes_reg;
        k_next        = k_reg;
        n_next        = n_reg;
        bad_next      = bad_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_char_next   = m_char_reg;
        m_last_next   = m_last_reg;
        m_ok_next     = m_ok_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    axes_next  = axes_init;
                    bad_next   = in_bad;
                    n_next     = n_clamp;
                    k_next     = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (load) begin
                    m_tvalid_next = 1'b1;
                    m_last_next   = last_now;
                    m_ok_next     = !bad_reg;
                    m_char_next   = bad_reg ? '0 : geo_pkg::ALPHABET[sym];
                    axes_next     = chain[NCELL];
                    k_next        = k_reg + CNT_W'(1);
                    if (last_now) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_tvalid_reg   <= 1'b0;
            char_count_reg <= geo_pkg::CNT_CFG_W'(12);
            k_reg          <= '0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            k_reg        <= k_next;
            if (cfg_we) begin
                char_count_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        axes_reg   <= axes_next;
        n_reg      <= n_next;
        bad_reg    <= bad_next;
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
        m_ok_reg   <= m_ok_next;
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = {1'b0, m_char_reg};
    assign m_tlast    = m_last_reg;
    assign m_tuser[0] = m_ok_reg;

    a_bad_single : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast && (m_tdata == 8'h00))
        else $error("out of range item is not a single flagged zero");

    a_count_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) && !bad_reg |-> (k_reg < n_reg))
        else $error("character index ran past the count");

    a_last_idle : assert property (@(posedge aclk) disable iff (!aresetn)
        load && last_now |=> (state_reg == ST_IDLE) && m_tvalid && m_tlast)
        else $error("final character did not end the pair");

endmodule

### hw/rtl/geo_cell.sv
// geo_cell: one bisection step of the geohash chain
// compares the residual of the current axis with its half width, hands on swapped axes
// depends on geo_pkg
module geo_cell (
    input  geo_pkg::geo_axes_t axes_in,
    output geo_pkg::geo_axes_t axes_out,
    output logic               bit_out
);

    logic [geo_pkg::RES_W:0] diff;

    assign diff    = {1'b0, axes_in.cur_r} - {1'b0, axes_in.cur_h};
    assign bit_out = !diff[geo_pkg::RES_W] && (diff[geo_pkg::RES_W-1:0] != '0);

    always_comb begin
        axes_out.cur_r = axes_in.oth_r;
        axes_out.cur_h = axes_in.oth_h;
        axes_out.oth_r = bit_out ? diff[geo_pkg::RES_W-1:0] : axes_in.cur_r;
        axes_out.oth_h = axes_in.cur_h >> 1;
    end

endmodule

### tb/geohash_encoder_tb.sv
// geohash_encoder_tb: self-checking testbench of the geohash encoder
// drives coordinate pairs in bursts, stalls the character stream, predicts every character
// depends on geo_pkg and the geohash_encoder rtl
module geohash_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  FRAC      = 20;
    localparam int  ONE       = 1 << FRAC;
    localparam int  CYC_LIMIT = 400000;
    localparam int  TAIL      = 30;

    typedef struct packed {
        logic [geo_pkg::CHAR_W-1:0] ch;
        logic                       last;
        logic                       ok;
    } hash_item_t;

    class hash_checker;
        hash_item_t  pending_chars[$];
        int unsigned count_reg;
        int unsigned errors;
        int unsigned checked;
        string       alpha;

        function new();
            count_reg = 12;
            errors    = 0;
            checked   = 0;
            alpha     = "0123456789bcdefghjkmnpqrstuvwxyz";
        endfunction

        function void set_count(logic [geo_pkg::CNT_CFG_W-1:0] v);
            count_reg = 32'(v);
        endfunction

        // bisect both axes in 2^-52 degree units, offset to non-negative values
        function void note_pair(logic signed [27:0] lat, logic signed [28:0] lng);
            longint     la;
            longint     lo;
            bit [63:0]  lat_c, lng_c, lat_lo, lat_hi, lng_lo, lng_hi, mid, c;
            int         n;
            bit [4:0]   sym;
            bit         on_lng;
            hash_item_t e;
            la = longint'(lat);
            lo = longint'(lng);
            if (la > 90 * ONE || la < -90 * ONE || lo > 180 * ONE || lo < -180 * ONE) begin
                e.ch   = '0;
                e.last = 1'b1;
                e.ok   = 1'b0;
                pending_chars.push_back(e);
                return;
            end
            n = count_reg;
            if (n < 1) n = 1;
            if (n > 12) n = 12;
            lat_c  = 64'(la + 90 * ONE) << (52 - FRAC);
            lng_c  = 64'(lo + 180 * ONE) << (52 - FRAC);
            lat_lo = 0;
            lat_hi = 64'd180 << 52;
            lng_lo = 0;
            lng_hi = 64'd360 << 52;
            on_lng = 1'b1;
            for (int k = 0; k < n; k++) begin
                sym = '0;
                for (int b = 0; b < 5; b++) begin
                    if (on_lng) begin
                        mid = lng_lo + ((lng_hi - lng_lo) >> 1);
                        c   = lng_c;
                    end else begin
                        mid = lat_lo + ((lat_hi - lat_lo) >> 1);
                        c   = lat_c;
                    end
                    sym = {sym[3:0], c > mid};
                    if (on_lng) begin
                        if (c > mid) lng_lo = mid;
                        else lng_hi = mid;
                    end else begin
                        if (c > mid) lat_lo = mid;
                        else lat_hi = mid;
                    end
                    on_lng = !on_lng;
                end
                e.ch   = geo_pkg::CHAR_W'(alpha[sym]);
                e.last = (k == n - 1);
                e.ok   = 1'b1;
                pending_chars.push_back(e);
            end
        endfunction

        function void check_char(hash_item_t got);
            hash_item_t want;
            checked++;
            if (pending_chars.size() == 0) begin
                errors++;
                $display("%0t: unexpected item ch=%h last=%b ok=%b",
                         $time, got.ch, got.last, got.ok);
                return;
            end
            want = pending_chars.pop_front();
            if (got.ch !== want.ch) begin
                errors++;
                $display("%0t: hash_char expected %h actual %h", $time, want.ch, got.ch);
            end
            if (got.last !== want.last) begin
                errors++;
                $display("%0t: last expected %b actual %b", $time, want.last, got.last);
            end
            if (got.ok !== want.ok) begin
                errors++;
                $display("%0t: valid_res expected %b actual %b", $time, want.ok, got.ok);
            end
        endfunction

        function int unsigned pending();
            return pending_chars.size();
        endfunction
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [3:0]  cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic [0:0]  m_tuser;

    hash_checker sb = new();
    hash_item_t  mon_item;
    int unsigned cycles    = 0;
    int unsigned pairs_in  = 0;
    int unsigned burst_left = 0;
    int unsigned settings  = 1;
    int unsigned rx_mode   = 0;
    int unsigned rx_count  = 0;

    geohash_encoder #(
        .MAX_CHARS      (12),
        .COORD_FRAC_BITS(FRAC)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYC_LIMIT) begin
            $display("timeout after %0d cycles, %0d items still expected", cycles, sb.pending());
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver stall pattern in one of four modes, picked at random
    always @(posedge aclk) begin
        rx_count <= rx_count + 1;
        if (rx_count % 97 == 0) rx_mode <= $urandom_range(0, 3);
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 7) != 0);
            default: m_tready <= (rx_count % 8 < 3);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            mon_item.ch   = m_tdata[geo_pkg::CHAR_W-1:0];
            mon_item.last = m_tlast;
            mon_item.ok   = m_tuser[0];
            sb.check_char(mon_item);
        end
    end

    task automatic send_pair(logic signed [27:0] lat, logic signed [28:0] lng, bit gaps);
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, lng, lat};
        do @(posedge aclk); while (!s_tready);
        sb.note_pair(lat, lng);
        pairs_in++;
        if (gaps) begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 25) : $urandom_range(0, 6);
                burst_left = $urandom_range(1, 16);
                if (gap != 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_char_count(logic [3:0] v);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.set_count(v);
        settings++;
    endtask

    task automatic random_pair(output logic signed [27:0] lat, output logic signed [28:0] lng);
        int unsigned pick;
        longint      la, lo;
        pick = $urandom_range(0, 99);
        la = longint'($urandom_range(0, 180 * ONE)) - longint'(90 * ONE);
        lo = longint'($urandom_range(0, 360 * ONE)) - longint'(180 * ONE);
        if (pick < 10) begin
            // raw field patterns, mostly out of range
            la = longint'($signed(28'($urandom())));
            lo = longint'($signed(29'($urandom())));
        end else if (pick < 20) begin
            // edges of the valid range
            case ($urandom_range(0, 5))
                0: la = longint'(90 * ONE);
                1: la = longint'(-90 * ONE);
                2: la = longint'(90 * ONE) + longint'($urandom_range(0, 1));
                3: lo = longint'(180 * ONE);
                4: lo = longint'(-180 * ONE) - longint'($urandom_range(0, 1));
                default: lo = longint'(180 * ONE) + longint'($urandom_range(0, 1));
            endcase
        end
        lat = la[27:0];
        lng = lo[28:0];
    endtask

    initial begin
        logic signed [27:0] lat;
        logic signed [28:0] lng;
        longint dir_lat[] = '{0, 1, -1, 90 * ONE, -90 * ONE, 90 * ONE, -90 * ONE,
                              45 * ONE, -45 * ONE, 90 * ONE - 1, -90 * ONE + 1,
                              90 * ONE + 1, -90 * ONE - 1, 0, 0,
                              134217727, -134217728, 39610000, -33000000};
        longint dir_lng[] = '{0, 1, -1, 180 * ONE, -180 * ONE, -180 * ONE, 180 * ONE,
                              90 * ONE, -90 * ONE, 180 * ONE - 1, -180 * ONE + 1,
                              0, 0, 180 * ONE + 1, -180 * ONE - 1,
                              268435455, -268435456, -128366000, 151000000};
        int cfg_list[] = '{1, 5, 0, 15, 2, 13, 8, 12, 3, 14, 11, 6, 4, 9, 10, 7};
        int n_rand;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset count of 12, directed pairs back to back
        for (int i = 0; i < dir_lat.size(); i++) begin
            lat = dir_lat[i][27:0];
            lng = dir_lng[i][28:0];
            send_pair(lat, lng, 1'b0);
        end
        for (int i = 0; i < 15; i++) begin
            random_pair(lat, lng);
            send_pair(lat, lng, 1'b1);
        end

        foreach (cfg_list[p]) begin
            set_char_count(4'(cfg_list[p]));
            n_rand = $urandom_range(12, 20);
            for (int i = 0; i < n_rand; i++) begin
                random_pair(lat, lng);
                send_pair(lat, lng, (p % 5) != 2);
            end
        end

        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (TAIL) @(posedge aclk);

        $display("sent %0d coordinate pairs over %0d char_count settings, %0d characters checked",
                 pairs_in, settings, sb.checked);
        $display("covered range edges, out of range pairs, counts 0 to 15, bursty input, stalls");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches, %0d items still expected", sb.errors, sb.pending());
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
